// ===== hw/rtl/ffha_pkg.sv =====
// Shared constants, types and helpers of the first-fit heap allocator.
package ffha_pkg;

	localparam int HEAP_BYTES   = 65536;
	localparam int HEADER_BYTES = 24;
	localparam int ALIGN        = 8;
	localparam int MIN_PAYLOAD  = 8;

	localparam int OFF_W    = $clog2(HEAP_BYTES);
	localparam int PTR_W    = OFF_W + 1;
	localparam int ALIGN_SH = $clog2(ALIGN);
	localparam int DEPTH    = HEAP_BYTES / ALIGN;
	localparam int IDX_W    = $clog2(DEPTH);
	localparam int ENTRY_W  = OFF_W + 1;
	localparam int CNT_W    = 14;
	localparam int FLD_W    = 16;

	localparam logic [1:0] REQ_ALLOC   = 2'd0;
	localparam logic [1:0] REQ_FREE    = 2'd1;
	localparam logic [1:0] REQ_REALLOC = 2'd2;
	localparam logic [1:0] REQ_STATS   = 2'd3;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_OOM  = 2'd1;
	localparam logic [1:0] ST_NULL = 2'd2;

	typedef struct packed {
		logic             free;
		logic [OFF_W-1:0] size;
	} entry_t;

	typedef struct packed {
		logic       load;
		logic       walk_clr;
		logic       step;
		logic       cap_found;
		logic       init_wr;
		logic       take_wr;
		logic       take_wr2;
		logic       take_res;
		logic       inplace_res;
		logic       rel_rd;
		logic       rel_wr;
		logic       stat_acc;
		logic       finish;
		logic [1:0] st;
	} cmd_t;

	typedef struct packed {
		logic       last;
		logic       match;
		logic       fit;
		logic       split;
		logic       inplace;
		logic       n_zero;
		logic       present;
		logic       found;
		logic       out_busy;
		logic [1:0] req;
	} stat_t;

	function automatic logic [IDX_W-1:0] to_idx(input logic [PTR_W-1:0] p);
		return p[IDX_W+ALIGN_SH-1:ALIGN_SH];
	endfunction

endpackage

// ===== hw/rtl/ffha_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ffha_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== hw/rtl/ffha_ctrl.sv =====
// Controller state machine that sequences the chunk walks of each request.
module ffha_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  ffha_pkg::stat_t stat,
	output ffha_pkg::cmd_t  cmd
);
	typedef enum logic [12:0] {
		S_INIT = 13'b0000000000001,
		S_IDLE = 13'b0000000000010,
		S_DISP = 13'b0000000000100,
		S_FRD  = 13'b0000000001000,
		S_FEV  = 13'b0000000010000,
		S_TRD  = 13'b0000000100000,
		S_TEV  = 13'b0000001000000,
		S_TWR2 = 13'b0000010000000,
		S_SRD  = 13'b0000100000000,
		S_SEV  = 13'b0001000000000,
		S_RRD  = 13'b0010000000000,
		S_REV  = 13'b0100000000000,
		S_POST = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   phase2_q, phase2_d;
	logic [1:0] rel_st_q, rel_st_d;

	assign in_ready = (state_q == S_IDLE) && !stat.out_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			phase2_q <= 1'b0;
			rel_st_q <= ffha_pkg::ST_DONE;
		end else begin
			state_q  <= state_d;
			phase2_q <= phase2_d;
			rel_st_q <= rel_st_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		phase2_d = phase2_q;
		rel_st_d = rel_st_q;
		cmd      = '0;
		cmd.st   = ffha_pkg::ST_DONE;
		unique case (state_q)
			S_INIT: begin
				cmd.init_wr = 1'b1;
				state_d     = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.load = 1'b1;
					phase2_d = 1'b0;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				cmd.walk_clr = 1'b1;
				unique case (stat.req)
					ffha_pkg::REQ_ALLOC: begin
						if (stat.n_zero) begin
							cmd.finish = 1'b1;
							cmd.st     = ffha_pkg::ST_NULL;
							state_d    = S_IDLE;
						end else begin
							state_d = S_TRD;
						end
					end
					ffha_pkg::REQ_FREE: begin
						if (!stat.present) begin
							cmd.finish = 1'b1;
							cmd.st     = ffha_pkg::ST_NULL;
							state_d    = S_IDLE;
						end else begin
							state_d = S_FRD;
						end
					end
					ffha_pkg::REQ_REALLOC: begin
						if (stat.present) begin
							state_d = S_FRD;
						end else if (stat.n_zero) begin
							cmd.finish = 1'b1;
							cmd.st     = ffha_pkg::ST_NULL;
							state_d    = S_IDLE;
						end else begin
							state_d = S_TRD;
						end
					end
					default: state_d = S_SRD;
				endcase
			end
			S_FRD: state_d = S_FEV;
			S_FEV: begin
				if (stat.match) begin
					cmd.cap_found = 1'b1;
					if (phase2_q || stat.req == ffha_pkg::REQ_FREE) begin
						rel_st_d = ffha_pkg::ST_DONE;
						state_d  = S_RRD;
					end else if (stat.n_zero) begin
						rel_st_d = ffha_pkg::ST_NULL;
						state_d  = S_RRD;
					end else begin
						state_d = S_POST;
					end
				end else if (stat.last) begin
					if (stat.req == ffha_pkg::REQ_FREE || stat.n_zero) begin
						cmd.finish = 1'b1;
						cmd.st     = ffha_pkg::ST_NULL;
						state_d    = S_IDLE;
					end else begin
						cmd.walk_clr = 1'b1;
						state_d      = S_TRD;
					end
				end else begin
					cmd.step = 1'b1;
					state_d  = S_FRD;
				end
			end
			S_POST: begin
				if (stat.inplace) begin
					cmd.inplace_res = 1'b1;
					cmd.finish      = 1'b1;
					state_d         = S_IDLE;
				end else begin
					cmd.walk_clr = 1'b1;
					state_d      = S_TRD;
				end
			end
			S_TRD: state_d = S_TEV;
			S_TEV: begin
				if (stat.fit) begin
					cmd.take_wr  = 1'b1;
					cmd.take_res = 1'b1;
					if (stat.split) begin
						state_d = S_TWR2;
					end else if (stat.found) begin
						cmd.walk_clr = 1'b1;
						phase2_d     = 1'b1;
						state_d      = S_FRD;
					end else begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				end else if (stat.last) begin
					cmd.finish = 1'b1;
					cmd.st     = ffha_pkg::ST_OOM;
					state_d    = S_IDLE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_TRD;
				end
			end
			S_TWR2: begin
				cmd.take_wr2 = 1'b1;
				if (stat.found) begin
					cmd.walk_clr = 1'b1;
					phase2_d     = 1'b1;
					state_d      = S_FRD;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_SRD: state_d = S_SEV;
			S_SEV: begin
				cmd.stat_acc = 1'b1;
				if (stat.last) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.step = 1'b1;
					state_d  = S_SRD;
				end
			end
			S_RRD: begin
				cmd.rel_rd = 1'b1;
				state_d    = S_REV;
			end
			S_REV: begin
				cmd.rel_wr = 1'b1;
				cmd.finish = 1'b1;
				cmd.st     = rel_st_q;
				state_d    = S_IDLE;
			end
			default: state_d = S_INIT;
		endcase
	end

	cmd_excl_a: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take_wr2 |-> $past(cmd.take_wr))
		else $error("Split write without a preceding take write.");
	load_a: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == S_DISP))
		else $error("Accepted transfer was not dispatched.");
endmodule

// ===== hw/rtl/ffha_dp.sv =====
// Datapath: chunk memory, walk pointers, release merge and result registers.
module ffha_dp (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ffha_pkg::cmd_t            cmd,
	output ffha_pkg::stat_t           stat,
	input  logic [1:0]                in_req,
	input  logic [ffha_pkg::FLD_W-1:0] in_bytes,
	input  logic [ffha_pkg::FLD_W-1:0] in_off,
	input  logic                      in_present,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [1:0]                out_status,
	output logic [ffha_pkg::FLD_W-1:0] out_offset,
	output logic                      out_present,
	output logic [ffha_pkg::FLD_W-1:0] out_copy,
	output logic [ffha_pkg::FLD_W-1:0] out_used,
	output logic [ffha_pkg::FLD_W-1:0] out_free,
	output logic [ffha_pkg::CNT_W-1:0] out_count
);
	localparam int PW = ffha_pkg::PTR_W;
	localparam int OW = ffha_pkg::OFF_W;
	localparam logic [PW-1:0] HDR  = PW'(ffha_pkg::HEADER_BYTES);
	localparam logic [PW-1:0] HEAP = PW'(ffha_pkg::HEAP_BYTES);
	localparam logic [PW-1:0] AMSK = PW'(ffha_pkg::ALIGN - 1);
	localparam logic [PW:0]   SPLT = (PW+1)'(ffha_pkg::HEADER_BYTES + ffha_pkg::MIN_PAYLOAD);

	logic [1:0]    req_q;
	logic [ffha_pkg::FLD_W-1:0] n_q, off_q;
	logic          present_q, found_q;
	logic [PW-1:0] need_q, cur_q, prev_start_q;
	logic          prev_free_q, prev_valid_q;
	logic [OW-1:0] prev_size_q, f_size_q;
	logic [PW-1:0] f_start_q;
	logic          valid_q;

	ffha_pkg::entry_t rd_e, wr_e;
	logic [ffha_pkg::IDX_W-1:0] waddr, raddr;
	logic          we;
	logic [PW-1:0] nxt, rel_next, msize, rem_start;
	logic [PW:0]   need_x;

	ffha_ram #(.WIDTH(ffha_pkg::ENTRY_W), .DEPTH(ffha_pkg::DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wr_e),
		.raddr (raddr),
		.rdata (rd_e)
	);

	assign nxt       = cur_q + HDR + PW'(rd_e.size);
	assign rel_next  = f_start_q + HDR + PW'(f_size_q);
	assign rem_start = cur_q + HDR + need_q;
	assign need_x    = (PW+1)'(need_q) + SPLT;
	assign msize     = PW'(f_size_q) +
		(((rel_next < HEAP) && rd_e.free) ? (HDR + PW'(rd_e.size)) : '0);

	assign raddr = cmd.rel_rd ? ffha_pkg::to_idx(rel_next) : ffha_pkg::to_idx(cur_q);

	always_comb begin
		we    = 1'b0;
		waddr = ffha_pkg::to_idx(cur_q);
		wr_e  = '0;
		if (cmd.init_wr) begin
			we    = 1'b1;
			waddr = '0;
			wr_e  = '{free: 1'b1, size: OW'(HEAP - HDR)};
		end else if (cmd.take_wr) begin
			we = 1'b1;
			if (stat.split) begin
				waddr = ffha_pkg::to_idx(rem_start);
				wr_e  = '{free: 1'b1, size: OW'(PW'(rd_e.size) - need_q - HDR)};
			end else begin
				wr_e = '{free: 1'b0, size: rd_e.size};
			end
		end else if (cmd.take_wr2) begin
			we   = 1'b1;
			wr_e = '{free: 1'b0, size: OW'(need_q)};
		end else if (cmd.rel_wr) begin
			we = 1'b1;
			if (prev_valid_q && prev_free_q) begin
				waddr = ffha_pkg::to_idx(prev_start_q);
				wr_e  = '{free: 1'b1, size: OW'(PW'(prev_size_q) + HDR + msize)};
			end else begin
				waddr = ffha_pkg::to_idx(f_start_q);
				wr_e  = '{free: 1'b1, size: OW'(msize)};
			end
		end
	end

	assign stat.last     = nxt >= HEAP;
	assign stat.match    = !rd_e.free && ((cur_q + HDR) == PW'(off_q));
	assign stat.fit      = rd_e.free && (PW'(rd_e.size) >= need_q);
	assign stat.split    = (PW+1)'(rd_e.size) >= need_x;
	assign stat.inplace  = need_q <= PW'(f_size_q);
	assign stat.n_zero   = (n_q == '0);
	assign stat.present  = present_q;
	assign stat.found    = found_q;
	assign stat.out_busy = valid_q;
	assign stat.req      = req_q;
	assign out_valid     = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.finish) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q       <= in_req;
			n_q         <= in_bytes;
			off_q       <= in_off;
			present_q   <= in_present;
			need_q      <= (PW'(in_bytes) + AMSK) & ~AMSK;
			found_q     <= 1'b0;
			out_offset  <= '0;
			out_present <= 1'b0;
			out_copy    <= '0;
			out_used    <= '0;
			out_free    <= '0;
			out_count   <= '0;
		end
		if (cmd.walk_clr) begin
			cur_q        <= '0;
			prev_valid_q <= 1'b0;
		end
		if (cmd.step) begin
			cur_q        <= nxt;
			prev_start_q <= cur_q;
			prev_free_q  <= rd_e.free;
			prev_size_q  <= rd_e.size;
			prev_valid_q <= 1'b1;
		end
		if (cmd.cap_found) begin
			found_q   <= 1'b1;
			f_start_q <= cur_q;
			f_size_q  <= rd_e.size;
		end
		if (cmd.take_res) begin
			out_offset  <= ffha_pkg::FLD_W'(cur_q + HDR);
			out_present <= 1'b1;
			out_copy    <= found_q ? ffha_pkg::FLD_W'(f_size_q) : '0;
		end
		if (cmd.inplace_res) begin
			out_offset  <= off_q;
			out_present <= 1'b1;
		end
		if (cmd.stat_acc) begin
			if (rd_e.free) begin
				out_free  <= out_free + ffha_pkg::FLD_W'(rd_e.size);
				out_count <= out_count + ffha_pkg::CNT_W'(1);
			end else begin
				out_used <= out_used + ffha_pkg::FLD_W'(rd_e.size);
			end
		end
		if (cmd.finish) begin
			out_status <= cmd.st;
		end
	end

	pres_a: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_present) |-> (out_status == ffha_pkg::ST_DONE))
		else $error("Returned block with a failing status.");
	copy_a: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_status != ffha_pkg::ST_DONE) |-> (out_copy == '0))
		else $error("Copy count on a failed request.");
	hold_a: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> $stable(out_offset) && $stable(out_status))
		else $error("Result changed while waiting.");
endmodule

// ===== hw/rtl/first_fit_heap_allocator.sv =====
// Top level of the first-fit heap allocator with coalescing.
// Each request walks the chunk chain from offset zero through one chunk RAM
// entry per ALIGN bytes; every chunk visited takes a RAM read state, then an
// evaluate state, and a realloc that moves its block walks up to three times,
// then reads and writes for the merge. There are at most 2048 chunks. After
// reset the S_INIT state writes the single free chunk before the first
// transfer is taken. One request is handled at a time; the result waits in an
// output register.
module first_fit_heap_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // request_bytes, block_offset, block_present, pad
	input  logic [1:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,  // result_offset, result_present, copy_bytes,
	                              // used_bytes, free_bytes, free_count, pad
	output logic [1:0]  m_tuser   // status
);
	ffha_pkg::cmd_t  cmd;
	ffha_pkg::stat_t stat;
	logic [15:0] roff, copy, used, freeb;
	logic [13:0] cnt;
	logic        rpres;

	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_req      (s_tuser),
		.in_bytes    (s_tdata[15:0]),
		.in_off      (s_tdata[31:16]),
		.in_present  (s_tdata[32]),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_status  (m_tuser),
		.out_offset  (roff),
		.out_present (rpres),
		.out_copy    (copy),
		.out_used    (used),
		.out_free    (freeb),
		.out_count   (cnt)
	);

	assign m_tdata = {1'b0, cnt, freeb, used, copy, rpres, roff};

	ready_a: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("Request taken while a result is pending.");
endmodule
